### hdl/rau_pkg.sv
// shared constants, command codes and control structs of the rational arithmetic unit
package rau_pkg;

   localparam int OpWidth = 32;
   localparam int ProdWidth = 2 * OpWidth;
   localparam int SumWidth = ProdWidth + 1;
   localparam int ShiftWidth = $clog2(SumWidth + 1);

   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_DIV = 3'd3;
   localparam logic [2:0] OP_CMP = 3'd4;
   localparam logic [2:0] OP_TRUNC = 3'd5;

   localparam logic [4:0] CMD_NONE      = 5'd0;
   localparam logic [4:0] CMD_LOAD      = 5'd1;
   localparam logic [4:0] CMD_LOAD_B    = 5'd2;
   localparam logic [4:0] CMD_CHECK     = 5'd3;
   localparam logic [4:0] CMD_GCD       = 5'd4;
   localparam logic [4:0] CMD_SHIFT     = 5'd5;
   localparam logic [4:0] CMD_DIV_N     = 5'd6;
   localparam logic [4:0] CMD_TAKE_N    = 5'd7;
   localparam logic [4:0] CMD_DIV_D     = 5'd8;
   localparam logic [4:0] CMD_TAKE_D    = 5'd9;
   localparam logic [4:0] CMD_STORE_A   = 5'd10;
   localparam logic [4:0] CMD_STORE_B   = 5'd11;
   localparam logic [4:0] CMD_STORE_R   = 5'd12;
   localparam logic [4:0] CMD_MUL_X     = 5'd13;
   localparam logic [4:0] CMD_MUL_Y     = 5'd14;
   localparam logic [4:0] CMD_MUL_D     = 5'd15;
   localparam logic [4:0] CMD_MUL_XN    = 5'd16;
   localparam logic [4:0] CMD_RECIP     = 5'd17;
   localparam logic [4:0] CMD_FORM_SUM  = 5'd18;
   localparam logic [4:0] CMD_FORM_PROD = 5'd19;
   localparam logic [4:0] CMD_CMP       = 5'd20;
   localparam logic [4:0] CMD_TRUNC_INV = 5'd21;
   localparam logic [4:0] CMD_DIV_T     = 5'd22;
   localparam logic [4:0] CMD_TAKE_T    = 5'd23;

   typedef struct packed {
      logic [4:0] code;
   } cmd_type;

   typedef struct packed {
      logic       special;
      logic       gcd_done;
      logic       div_done;
      logic       a_den_zero;
      logic [2:0] op;
   } stat_type;

endpackage

### hdl/rau_div.sv
// iterative restoring divider, one quotient bit per cycle
module rau_div import rau_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [SumWidth-1:0]   dividend,
   input  logic [ProdWidth-1:0]  divisor,
   output logic                  done,
   output logic [SumWidth-1:0]   quotient
);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [ShiftWidth-1:0]  count_ff, count_in;
   logic [SumWidth-1:0]    rem_ff, rem_in;
   logic [SumWidth-1:0]    quo_ff, quo_in;
   logic [ProdWidth-1:0]   dvs_ff, dvs_in;
   logic [SumWidth-1:0]    trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      count_in = count_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      trial = {rem_ff[ProdWidth-1:0], quo_ff[SumWidth-1]};
      if (start) begin
         busy_in = 1'b1;
         count_in = ShiftWidth'(SumWidth);
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[SumWidth-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[SumWidth-2:0], 1'b0};
         end
         count_in = count_ff - 1'b1;
         if (count_ff == ShiftWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

### hdl/rau_datapath.sv
// operand, product, reduction and result registers with the shared multiplier and divider
module rau_datapath import rau_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output stat_type             stat,
   input  logic [2:0]           req_opcode,
   input  logic                 req_a_negative,
   input  logic [OpWidth-1:0]   req_a_numerator,
   input  logic [OpWidth-1:0]   req_a_denominator,
   input  logic                 req_b_negative,
   input  logic [OpWidth-1:0]   req_b_numerator,
   input  logic [OpWidth-1:0]   req_b_denominator,
   output logic                 rsp_r_negative,
   output logic [OpWidth-1:0]   rsp_r_numerator,
   output logic [OpWidth-1:0]   rsp_r_denominator,
   output logic                 rsp_is_less,
   output logic                 rsp_is_equal,
   output logic                 rsp_is_invalid,
   output logic                 rsp_overflow
);

   logic [2:0]             op_ff, op_in;
   logic                   aneg_ff, aneg_in, bneg_ff, bneg_in;
   logic [OpWidth-1:0]     an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic [ProdWidth-1:0]   x_ff, x_in, y_ff, y_in, d_ff, d_in;
   logic [SumWidth-1:0]    cn_ff, cn_in;
   logic [ProdWidth-1:0]   cd_ff, cd_in;
   logic                   cneg_ff, cneg_in;
   logic                   kinv_ff, kinv_in, kzero_ff, kzero_in;
   logic [SumWidth-1:0]    u_ff, u_in, v_ff, v_in;
   logic [ShiftWidth-1:0]  k_ff, k_in;
   logic                   rneg_ff, rneg_in, rless_ff, rless_in, requal_ff, requal_in;
   logic                   rinv_ff, rinv_in, rovf_ff, rovf_in;
   logic [OpWidth-1:0]     rnum_ff, rnum_in, rden_ff, rden_in;

   logic                   sv_neg, sv_ovf;
   logic [SumWidth-1:0]    sv_num;
   logic [ProdWidth-1:0]   sv_den;
   logic [OpWidth-1:0]     mul_a, mul_b;
   logic [ProdWidth-1:0]   product;
   logic                   beff_neg;
   logic                   div_start, div_done;
   logic [SumWidth-1:0]    div_dividend, div_quotient;
   logic [ProdWidth-1:0]   div_divisor;

   rau_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // canonical value of the fraction under reduction
   always_comb begin
      if (kinv_ff) begin
         sv_neg = 1'b0;
         sv_num = SumWidth'(1);
         sv_den = '0;
         sv_ovf = 1'b0;
      end else if (kzero_ff) begin
         sv_neg = 1'b0;
         sv_num = '0;
         sv_den = ProdWidth'(1);
         sv_ovf = 1'b0;
      end else begin
         sv_neg = cneg_ff;
         sv_num = cn_ff;
         sv_den = cd_ff;
         sv_ovf = (|cn_ff[SumWidth-1:OpWidth]) || (|cd_ff[ProdWidth-1:OpWidth]);
      end
   end

   always_comb begin
      case (cmd.code)
         CMD_MUL_X: begin
            mul_a = an_ff;
            mul_b = bd_ff;
         end
         CMD_MUL_Y: begin
            mul_a = bn_ff;
            mul_b = ad_ff;
         end
         CMD_MUL_D: begin
            mul_a = ad_ff;
            mul_b = bd_ff;
         end
         default: begin
            mul_a = an_ff;
            mul_b = bn_ff;
         end
      endcase
      product = ProdWidth'(mul_a) * ProdWidth'(mul_b);
   end

   always_comb begin
      div_start = 1'b0;
      div_dividend = cn_ff;
      div_divisor = u_ff[ProdWidth-1:0];
      case (cmd.code)
         CMD_DIV_N: begin
            div_start = 1'b1;
         end
         CMD_DIV_D: begin
            div_start = 1'b1;
            div_dividend = {1'b0, cd_ff};
         end
         CMD_DIV_T: begin
            div_start = 1'b1;
            div_dividend = SumWidth'(an_ff);
            div_divisor = ProdWidth'(ad_ff);
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   always_comb begin
      op_in = op_ff;
      aneg_in = aneg_ff;
      bneg_in = bneg_ff;
      an_in = an_ff;
      ad_in = ad_ff;
      bn_in = bn_ff;
      bd_in = bd_ff;
      x_in = x_ff;
      y_in = y_ff;
      d_in = d_ff;
      cn_in = cn_ff;
      cd_in = cd_ff;
      cneg_in = cneg_ff;
      kinv_in = kinv_ff;
      kzero_in = kzero_ff;
      u_in = u_ff;
      v_in = v_ff;
      k_in = k_ff;
      rneg_in = rneg_ff;
      rless_in = rless_ff;
      requal_in = requal_ff;
      rinv_in = rinv_ff;
      rovf_in = rovf_ff;
      rnum_in = rnum_ff;
      rden_in = rden_ff;
      beff_neg = bneg_ff ^ (op_ff == OP_SUB);
      case (cmd.code)
         CMD_LOAD: begin
            op_in = req_opcode;
            aneg_in = req_a_negative;
            an_in = req_a_numerator;
            ad_in = req_a_denominator;
            bneg_in = req_b_negative;
            bn_in = req_b_numerator;
            bd_in = req_b_denominator;
            cn_in = SumWidth'(req_a_numerator);
            cd_in = ProdWidth'(req_a_denominator);
            cneg_in = req_a_negative;
            rneg_in = 1'b0;
            rless_in = 1'b0;
            requal_in = 1'b0;
            rinv_in = 1'b0;
            rovf_in = 1'b0;
            rnum_in = '0;
            rden_in = '0;
         end
         CMD_LOAD_B: begin
            cn_in = SumWidth'(bn_ff);
            cd_in = ProdWidth'(bd_ff);
            cneg_in = bneg_ff;
         end
         CMD_CHECK: begin
            kinv_in = (cd_ff == '0);
            kzero_in = (cn_ff == '0);
            u_in = cn_ff;
            v_in = {1'b0, cd_ff};
            k_in = '0;
         end
         CMD_GCD: begin
            if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (u_ff > v_ff) begin
               u_in = (u_ff - v_ff) >> 1;
            end else begin
               v_in = (v_ff - u_ff) >> 1;
            end
         end
         CMD_SHIFT: begin
            // common power of two comes off before the odd part is divided out
            cn_in = cn_ff >> k_ff;
            cd_in = cd_ff >> k_ff;
         end
         CMD_TAKE_N: begin
            cn_in = div_quotient;
         end
         CMD_TAKE_D: begin
            cd_in = div_quotient[ProdWidth-1:0];
         end
         CMD_STORE_A: begin
            aneg_in = sv_neg;
            an_in = sv_num[OpWidth-1:0];
            ad_in = sv_den[OpWidth-1:0];
         end
         CMD_STORE_B: begin
            bneg_in = sv_neg;
            bn_in = sv_num[OpWidth-1:0];
            bd_in = sv_den[OpWidth-1:0];
         end
         CMD_STORE_R: begin
            rneg_in = sv_neg;
            rnum_in = sv_num[OpWidth-1:0];
            rden_in = sv_den[OpWidth-1:0];
            rovf_in = sv_ovf;
            rinv_in = kinv_ff;
         end
         CMD_MUL_X, CMD_MUL_XN: begin
            x_in = product;
         end
         CMD_MUL_Y: begin
            y_in = product;
         end
         CMD_MUL_D: begin
            d_in = product;
         end
         CMD_RECIP: begin
            if (bd_ff == '0) begin
               bneg_in = 1'b0;
               bn_in = '0;
               bd_in = OpWidth'(1);
            end else if (bn_ff == '0) begin
               bneg_in = 1'b0;
               bn_in = OpWidth'(1);
               bd_in = '0;
            end else begin
               bn_in = bd_ff;
               bd_in = bn_ff;
            end
         end
         CMD_FORM_SUM: begin
            cd_in = d_ff;
            if (aneg_ff == beff_neg) begin
               cn_in = {1'b0, x_ff} + {1'b0, y_ff};
               cneg_in = aneg_ff;
            end else if (x_ff >= y_ff) begin
               cn_in = {1'b0, x_ff - y_ff};
               cneg_in = aneg_ff;
            end else begin
               cn_in = {1'b0, y_ff - x_ff};
               cneg_in = !aneg_ff;
            end
         end
         CMD_FORM_PROD: begin
            cn_in = {1'b0, x_ff};
            cd_in = d_ff;
            cneg_in = aneg_ff ^ bneg_ff;
         end
         CMD_CMP: begin
            if (aneg_ff != bneg_ff) begin
               rless_in = aneg_ff;
            end else begin
               rless_in = aneg_ff ? (x_ff > y_ff) : (x_ff < y_ff);
            end
            requal_in = (aneg_ff == bneg_ff) && (an_ff == bn_ff) && (ad_ff == bd_ff);
         end
         CMD_TRUNC_INV: begin
            rinv_in = 1'b1;
         end
         CMD_TAKE_T: begin
            rnum_in = div_quotient[OpWidth-1:0];
            rden_in = OpWidth'(1);
            rneg_in = aneg_ff && (div_quotient[OpWidth-1:0] != '0);
         end
         default: begin
            op_in = op_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      aneg_ff <= aneg_in;
      bneg_ff <= bneg_in;
      an_ff <= an_in;
      ad_ff <= ad_in;
      bn_ff <= bn_in;
      bd_ff <= bd_in;
      x_ff <= x_in;
      y_ff <= y_in;
      d_ff <= d_in;
      cn_ff <= cn_in;
      cd_ff <= cd_in;
      cneg_ff <= cneg_in;
      kinv_ff <= kinv_in;
      kzero_ff <= kzero_in;
      u_ff <= u_in;
      v_ff <= v_in;
      k_ff <= k_in;
      rneg_ff <= rneg_in;
      rless_ff <= rless_in;
      requal_ff <= requal_in;
      rinv_ff <= rinv_in;
      rovf_ff <= rovf_in;
      rnum_ff <= rnum_in;
      rden_ff <= rden_in;
   end

   assign stat.special = (cd_ff == '0) || (cn_ff == '0);
   assign stat.gcd_done = (u_ff == v_ff);
   assign stat.div_done = div_done;
   assign stat.a_den_zero = (ad_ff == '0);
   assign stat.op = op_ff;

   assign rsp_r_negative = rneg_ff;
   assign rsp_r_numerator = rnum_ff;
   assign rsp_r_denominator = rden_ff;
   assign rsp_is_less = rless_ff;
   assign rsp_is_equal = requal_ff;
   assign rsp_is_invalid = rinv_ff;
   assign rsp_overflow = rovf_ff;

endmodule

### hdl/rau_ctrl.sv
// sequencer that steps the datapath through reduction, products and result forming
module rau_ctrl import rau_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   output logic     rsp_valid,
   output cmd_type  cmd,
   input  stat_type stat
);

   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_CHK   = 5'd1;
   localparam logic [4:0] ST_GCD   = 5'd2;
   localparam logic [4:0] ST_SHF   = 5'd3;
   localparam logic [4:0] ST_DVN   = 5'd4;
   localparam logic [4:0] ST_WTN   = 5'd5;
   localparam logic [4:0] ST_DVD   = 5'd6;
   localparam logic [4:0] ST_WTD   = 5'd7;
   localparam logic [4:0] ST_STO   = 5'd8;
   localparam logic [4:0] ST_LDB   = 5'd9;
   localparam logic [4:0] ST_MX    = 5'd10;
   localparam logic [4:0] ST_MY    = 5'd11;
   localparam logic [4:0] ST_MD    = 5'd12;
   localparam logic [4:0] ST_MXN   = 5'd13;
   localparam logic [4:0] ST_RCP   = 5'd14;
   localparam logic [4:0] ST_FSUM  = 5'd15;
   localparam logic [4:0] ST_FPROD = 5'd16;
   localparam logic [4:0] ST_CMP   = 5'd17;
   localparam logic [4:0] ST_TRD   = 5'd18;
   localparam logic [4:0] ST_TWT   = 5'd19;
   localparam logic [4:0] ST_DONE  = 5'd20;

   localparam logic [1:0] TGT_A = 2'd0;
   localparam logic [1:0] TGT_B = 2'd1;
   localparam logic [1:0] TGT_R = 2'd2;

   logic [4:0] state_ff, state_in;
   logic [1:0] tgt_ff, tgt_in;

   always_comb begin
      state_in = state_ff;
      tgt_in = tgt_ff;
      cmd.code = CMD_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.code = CMD_LOAD;
               tgt_in = TGT_A;
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            cmd.code = CMD_CHECK;
            state_in = stat.special ? ST_STO : ST_GCD;
         end
         ST_GCD: begin
            if (stat.gcd_done) begin
               state_in = ST_SHF;
            end else begin
               cmd.code = CMD_GCD;
            end
         end
         ST_SHF: begin
            cmd.code = CMD_SHIFT;
            state_in = ST_DVN;
         end
         ST_DVN: begin
            cmd.code = CMD_DIV_N;
            state_in = ST_WTN;
         end
         ST_WTN: begin
            if (stat.div_done) begin
               cmd.code = CMD_TAKE_N;
               state_in = ST_DVD;
            end
         end
         ST_DVD: begin
            cmd.code = CMD_DIV_D;
            state_in = ST_WTD;
         end
         ST_WTD: begin
            if (stat.div_done) begin
               cmd.code = CMD_TAKE_D;
               state_in = ST_STO;
            end
         end
         ST_STO: begin
            case (tgt_ff)
               TGT_A: begin
                  cmd.code = CMD_STORE_A;
                  state_in = ST_LDB;
               end
               TGT_B: begin
                  cmd.code = CMD_STORE_B;
                  case (stat.op)
                     OP_ADD, OP_SUB, OP_CMP: state_in = ST_MX;
                     OP_MUL: state_in = ST_MXN;
                     OP_DIV: state_in = ST_RCP;
                     OP_TRUNC: state_in = ST_TRD;
                     default: state_in = ST_DONE;
                  endcase
               end
               default: begin
                  cmd.code = CMD_STORE_R;
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_LDB: begin
            cmd.code = CMD_LOAD_B;
            tgt_in = TGT_B;
            state_in = ST_CHK;
         end
         ST_MX: begin
            cmd.code = CMD_MUL_X;
            state_in = ST_MY;
         end
         ST_MY: begin
            cmd.code = CMD_MUL_Y;
            state_in = (stat.op == OP_CMP) ? ST_CMP : ST_MD;
         end
         ST_RCP: begin
            cmd.code = CMD_RECIP;
            state_in = ST_MXN;
         end
         ST_MXN: begin
            cmd.code = CMD_MUL_XN;
            state_in = ST_MD;
         end
         ST_MD: begin
            cmd.code = CMD_MUL_D;
            state_in = (stat.op == OP_ADD || stat.op == OP_SUB) ? ST_FSUM : ST_FPROD;
         end
         ST_FSUM: begin
            cmd.code = CMD_FORM_SUM;
            tgt_in = TGT_R;
            state_in = ST_CHK;
         end
         ST_FPROD: begin
            cmd.code = CMD_FORM_PROD;
            tgt_in = TGT_R;
            state_in = ST_CHK;
         end
         ST_CMP: begin
            cmd.code = CMD_CMP;
            state_in = ST_DONE;
         end
         ST_TRD: begin
            if (stat.a_den_zero) begin
               cmd.code = CMD_TRUNC_INV;
               state_in = ST_DONE;
            end else begin
               cmd.code = CMD_DIV_T;
               state_in = ST_TWT;
            end
         end
         ST_TWT: begin
            if (stat.div_done) begin
               cmd.code = CMD_TAKE_T;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tgt_ff <= TGT_A;
      end else begin
         state_ff <= state_in;
         tgt_ff <= tgt_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

endmodule

### hdl/rational_arithmetic_unit_core.sv
// the shortest item is an unused opcode with zero or invalid operands, whose reductions skip
// the gcd and divider; each other fraction reduction runs a binary gcd and two passes of the
// shared divider, and up to three reductions occur
// throughput: one item at a time, a new start is taken the cycle after rsp_valid
// rsp_valid strobes for one cycle; the receiver cannot stall it
// synchronous active-high reset returns the sequencer to idle and drops busy
module rational_arithmetic_unit_core import rau_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [2:0]          req_opcode,
   input  logic                req_a_negative,
   input  logic [OpWidth-1:0]  req_a_numerator,
   input  logic [OpWidth-1:0]  req_a_denominator,
   input  logic                req_b_negative,
   input  logic [OpWidth-1:0]  req_b_numerator,
   input  logic [OpWidth-1:0]  req_b_denominator,
   output logic                rsp_valid,
   output logic                rsp_r_negative,
   output logic [OpWidth-1:0]  rsp_r_numerator,
   output logic [OpWidth-1:0]  rsp_r_denominator,
   output logic                rsp_is_less,
   output logic                rsp_is_equal,
   output logic                rsp_is_invalid,
   output logic                rsp_overflow
);

   cmd_type  cmd;
   stat_type stat;

   rau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .stat      (stat)
   );

   rau_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_opcode        (req_opcode),
      .req_a_negative    (req_a_negative),
      .req_a_numerator   (req_a_numerator),
      .req_a_denominator (req_a_denominator),
      .req_b_negative    (req_b_negative),
      .req_b_numerator   (req_b_numerator),
      .req_b_denominator (req_b_denominator),
      .rsp_r_negative    (rsp_r_negative),
      .rsp_r_numerator   (rsp_r_numerator),
      .rsp_r_denominator (rsp_r_denominator),
      .rsp_is_less       (rsp_is_less),
      .rsp_is_equal      (rsp_is_equal),
      .rsp_is_invalid    (rsp_is_invalid),
      .rsp_overflow      (rsp_overflow)
   );

   // a beat is only shown while an item is in flight
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result strobe without item in flight");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted item did not raise busy");

   a_free_after: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("unit still busy after result beat");

   a_invalid_den: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_invalid) |-> (rsp_r_denominator == '0))
      else $error("invalid result with nonzero denominator");

   a_less_equal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_is_less && rsp_is_equal))
      else $error("compare reports both less and equal");

endmodule
